// File: sv/segdisp_pkg.sv
// Package for the segment display scan driver: item types and glyph ROM.
`timescale 1ns / 1ps

package segdisp_pkg;

  localparam int unsigned NumDigits = 8;
  localparam int unsigned DigitW    = 3;
  localparam int unsigned SegW      = 8;
  localparam int unsigned GlyphNum  = 36;

  // Item function codes
  localparam logic FuncWrite = 1'b0;
  localparam logic FuncScan  = 1'b1;

  // Port idle levels (active-low outputs)
  localparam logic [5:0] PortCIdle = 6'h3f;
  localparam logic [7:0] PortDIdle = 8'hfc;
  localparam logic [3:0] PortEIdle = 4'h0f;

  typedef struct packed {
    logic       func;
    logic [3:0] position;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic [2:0] digit_index;
    logic [5:0] port_c_value;
    logic [7:0] port_d_value;
    logic [3:0] port_e_value;
  } out_t;

  // Glyphs for 0-9 then A-Z (letters share one set for both cases)
  localparam logic [SegW-1:0] GlyphRom [GlyphNum] = '{
    8'hDD, 8'h50, 8'hEC, 8'hF8, 8'h71, 8'hB9, 8'hBD, 8'hD0, 8'hFD, 8'hF9,
    8'hF5, 8'h3D, 8'h8D, 8'h00, 8'hAD, 8'h00, 8'h9D, 8'h75, 8'h04, 8'hDC,
    8'h00, 8'h50, 8'hD5, 8'h34, 8'h00, 8'hE5, 8'h00, 8'h24, 8'hB9, 8'h00,
    8'h5D, 8'h5D, 8'h00, 8'h00, 8'h79, 8'h00
  };

endpackage

// File: sv/segdisp_glyph.sv
// ASCII to segment pattern encoder for the segment display scan driver.
`timescale 1ns / 1ps

module segdisp_glyph (
  input  logic [7:0]                     char_code_i,
  output logic [segdisp_pkg::SegW-1:0]   segments_o
);

  logic [7:0] offset;
  logic [5:0] rom_idx;
  logic       hit;

  // Map digits and both letter cases onto the 36-entry ROM
  always_comb begin
    offset  = 8'h00;
    hit     = 1'b1;
    case (char_code_i) inside
      [8'h30:8'h39]: offset = char_code_i - 8'h30;
      [8'h41:8'h5a]: offset = char_code_i - 8'h41 + 8'd10;
      [8'h61:8'h7a]: offset = char_code_i - 8'h61 + 8'd10;
      default:       hit    = 1'b0;
    endcase
    rom_idx = offset[5:0];
  end

  // Anything without a glyph shows blank
  assign segments_o = hit ? segdisp_pkg::GlyphRom[rom_idx] : '0;

endmodule

// File: sv/segment_display_scan_driver.sv
// Top level of the eight-digit multiplexed segment display scan driver.
//
// Usage: an item is taken when start is high and busy is low; busy is never
// raised, so one item may be given every clock. A write item (func = 0)
// encodes char_code into a segment pattern and stores it at the physical
// digit for position; positions 7 and above are dropped. A scan item
// (func = 1) produces one result: the active-low select and segment values
// for the current digit, after which the digit counter advances (7 wraps
// to 0). Write items produce no result.
// A scan item's result shows on result_o with valid_o high for exactly one
// cycle, after the input register and then the result register. Throughput
// is one item per clock, set by the store update and digit mux between the
// two registers.
// Items are handled strictly in order, so a write followed by a scan of the
// same digit shows the new pattern.
// Reset clears the digit store to blank, the digit counter to zero and
// drops any item in flight. The receiver cannot stall: each result must be
// taken in the cycle it is shown.
`timescale 1ns / 1ps

module segment_display_scan_driver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  segdisp_pkg::in_t    item_i,
  output logic                valid_o,
  output segdisp_pkg::out_t   result_o
);

  logic                           start_q;
  segdisp_pkg::in_t               item_q;
  logic [segdisp_pkg::SegW-1:0]   store_q [segdisp_pkg::NumDigits];
  logic [segdisp_pkg::DigitW-1:0] scan_q, scan_d;
  logic                           valid_q, valid_d;
  segdisp_pkg::out_t              result_q, result_d;
  logic [segdisp_pkg::SegW-1:0]   glyph;
  logic [segdisp_pkg::SegW-1:0]   seg;
  logic [segdisp_pkg::DigitW-1:0] slot;
  logic                           wr_en;

  assign busy = 1'b0;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_i;
  end

  segdisp_glyph u_glyph (
    .char_code_i (item_q.char_code),
    .segments_o  (glyph)
  );

  // Logical position to physical slot: reversed, skipping slot 4
  always_comb begin
    wr_en = start_q && (item_q.func == segdisp_pkg::FuncWrite);
    slot  = '0;
    case (item_q.position) inside
      [4'd0:4'd2]: slot = 3'd7 - item_q.position[2:0];
      [4'd3:4'd6]: slot = 3'd6 - item_q.position[2:0];
      default:     wr_en = 1'b0;
    endcase
  end

  // Digit store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < segdisp_pkg::NumDigits; i++) begin
        store_q[i] <= '0;
      end
    end else if (wr_en) begin
      store_q[slot] <= glyph;
    end
  end

  // Scan result for the current digit
  always_comb begin
    valid_d  = start_q && (item_q.func == segdisp_pkg::FuncScan);
    scan_d   = valid_d ? scan_q + 3'd1 : scan_q;
    seg      = store_q[scan_q];
    result_d.digit_index  = scan_q;
    result_d.port_c_value = segdisp_pkg::PortCIdle;
    result_d.port_e_value = segdisp_pkg::PortEIdle;
    if (scan_q <= 3'd5) begin
      result_d.port_c_value[3'd5 - scan_q] = 1'b0;
    end else begin
      // digit 6 on bit 3, digit 7 on bit 2
      result_d.port_e_value[scan_q[0] ? 2 : 3] = 1'b0;
    end
    result_d.port_d_value = segdisp_pkg::PortDIdle & ~(seg & 8'hfc);
    result_d.port_e_value[1:0] = ~seg[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      scan_q  <= scan_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

  // A result only ever follows a taken scan item, through the input and result registers
  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy && item_i.func == segdisp_pkg::FuncScan, 2))
    else $error("result without a scan item");

  // Exactly one digit select is active per result
  a_one_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $countones({result_o.port_c_value, result_o.port_e_value[3:2]}) == 7)
    else $error("digit select not one-cold");

  // Consecutive results scan consecutive digits
  a_scan_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && $past(valid_o) |->
      result_o.digit_index == $past(result_o.digit_index) + 3'd1)
    else $error("digit counter skipped");

  // Unused segment bits stay zero
  a_pd_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> result_o.port_d_value[1:0] == 2'b00)
    else $error("port d low bits set");

endmodule
